FILE: src/assert_macros.svh
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/pcop_pkg.sv
package pcop_pkg;
    localparam int KIND_W = 2;
    localparam logic [1:0] KIND_LINE = 2'd0;
    localparam logic [1:0] KIND_CORNER_LOW = 2'd1;
    localparam logic [1:0] KIND_CORNER_HIGH = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam logic [15:0] TOL_RESET = 16'd13;

    // Controller states.
    typedef enum logic [2:0] {
        t_st_idle = 3'd0,
        t_st_load = 3'd1,
        t_st_sq   = 3'd2,
        t_st_root = 3'd3,
        t_st_next = 3'd4,
        t_st_out  = 3'd5
    } t_state;
endpackage

FILE: src/pcop_in_if.sv
interface pcop_in_if #(parameter int COORD_WIDTH = 16);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic signed [COORD_WIDTH-1:0] z_coord;
    logic last_point;
    modport source (output valid, x_coord, y_coord, z_coord, last_point, input ready);
    modport sink (input valid, x_coord, y_coord, z_coord, last_point, output ready);
endinterface

FILE: src/pcop_out_if.sv
interface pcop_out_if #(parameter int COORD_WIDTH = 16);
    logic valid;
    logic ready;
    logic [1:0] outline_kind;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    modport source (output valid, outline_kind, first_x, first_y, first_z,
        second_x, second_y, second_z, input ready);
    modport sink (input valid, outline_kind, first_x, first_y, first_z,
        second_x, second_y, second_z, output ready);
endinterface

FILE: src/point_cluster_outline_picker.sv
// Points are tracked at one transfer per cycle while a cluster is open. On the
// last point the block stops taking points and works out three distances in
// turn: each clears the accumulator in a load state, adds three squares through
// a bit-serial squarer, starts a bit-serial square root and captures the root.
// A final state classifies and offers the result, and the next point is taken
// in the cycle after the result's transfer.
`include "assert_macros.svh"
module point_cluster_outline_picker #(
    parameter int COORD_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    pcop_in_if.sink     in_ch,
    pcop_out_if.source  out_ch
);
    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int AW = 2 * DW + 2;
    localparam int RW = AW / 2;
    localparam int PW = 3 * CW;

    pcop_pkg::t_state r_state, n_state;
    logic [15:0]   r_tol;
    logic          r_seen;
    logic [PW-1:0] r_gy, r_ly, r_lx;
    logic [1:0]    r_pair, r_axis;
    logic [RW-1:0] r_dl, r_dr, r_dt;
    logic          r_ovalid;
    logic [1:0]    r_kind;
    logic [PW-1:0] r_p1, r_p2;
    logic          r_sq_start_d;

    logic          in_go, sq_busy, rt_busy, sq_clear, sq_start, rt_start;
    logic [AW-1:0] sq_sum;
    logic [RW-1:0] root;
    logic [PW-1:0] pa, pb, cur;
    logic signed [CW-1:0] ca, cb;
    logic signed [CW:0] sd;
    logic [DW-1:0] ad;
    logic [RW+16:0] sum_lr, lhs1, rhs1, lhs2;

    assign cur = {in_ch.x_coord, in_ch.y_coord, in_ch.z_coord};
    assign in_ch.ready = (r_state == pcop_pkg::t_st_idle);
    assign in_go = in_ch.valid && in_ch.ready;

    // Tolerance register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= pcop_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // Extreme tracking; fields packed as {x, y, z}.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (in_go) begin
            r_seen <= !in_ch.last_point;
        end
        if (in_go) begin
            if (!r_seen) begin
                r_gy <= cur;
                r_ly <= cur;
                r_lx <= cur;
            end else begin
                if ($signed(in_ch.y_coord) > $signed(r_gy[2*CW-1:CW])) r_gy <= cur;
                if ($signed(in_ch.y_coord) < $signed(r_ly[2*CW-1:CW])) r_ly <= cur;
                if ($signed(in_ch.x_coord) < $signed(r_lx[3*CW-1:2*CW])) r_lx <= cur;
            end
        end
    end

    // Pair 0 is left, 1 right, 2 total; axis 0..2 picks x, y, z, and 3 means
    // all three squares have been started.
    always_comb begin
        unique case (r_pair)
            2'd0: begin pa = r_gy; pb = r_lx; end
            2'd1: begin pa = r_ly; pb = r_lx; end
            default: begin pa = r_gy; pb = r_ly; end
        endcase
        unique case (r_axis)
            2'd0: begin ca = pa[3*CW-1:2*CW]; cb = pb[3*CW-1:2*CW]; end
            2'd1: begin ca = pa[2*CW-1:CW]; cb = pb[2*CW-1:CW]; end
            default: begin ca = pa[CW-1:0]; cb = pb[CW-1:0]; end
        endcase
        sd = (CW+1)'(ca) - (CW+1)'(cb);
        ad = sd[CW] ? DW'(-sd) : DW'(sd);
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcop_pkg::t_st_idle: if (in_go && in_ch.last_point) n_state = pcop_pkg::t_st_load;
            pcop_pkg::t_st_load: n_state = pcop_pkg::t_st_sq;
            pcop_pkg::t_st_sq: if (!sq_busy && !r_sq_start_d && r_axis == 2'd3)
                n_state = pcop_pkg::t_st_root;
            pcop_pkg::t_st_root: if (!rt_busy && !rt_start) n_state = pcop_pkg::t_st_next;
            pcop_pkg::t_st_next: n_state = (r_pair == 2'd2) ? pcop_pkg::t_st_out
                                                             : pcop_pkg::t_st_load;
            pcop_pkg::t_st_out: if (r_ovalid && out_ch.ready) n_state = pcop_pkg::t_st_idle;
            default: n_state = pcop_pkg::t_st_idle;
        endcase
    end

    // Unit control outputs.
    always_comb begin
        sq_clear = (r_state == pcop_pkg::t_st_load);
        sq_start = (r_state == pcop_pkg::t_st_sq && !sq_busy && !r_sq_start_d
                    && r_axis != 2'd3);
        rt_start = (r_state == pcop_pkg::t_st_sq && !sq_busy && !r_sq_start_d
                    && r_axis == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcop_pkg::t_st_idle;
            r_pair <= 2'd0;
            r_axis <= 2'd0;
            r_sq_start_d <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sq_start_d <= sq_start;
            if (r_state == pcop_pkg::t_st_idle) r_pair <= 2'd0;
            if (r_state == pcop_pkg::t_st_load) r_axis <= 2'd0;
            else if (sq_start) r_axis <= r_axis + 2'd1;
            if (r_state == pcop_pkg::t_st_next) r_pair <= r_pair + 2'd1;
        end
    end

    // Capture each distance when its root finishes.
    always_ff @(posedge i_clk) begin
        if (r_state == pcop_pkg::t_st_next) begin
            unique case (r_pair)
                2'd0: r_dl <= root;
                2'd1: r_dr <= root;
                default: r_dt <= root;
            endcase
        end
    end

    pcop_sq_acc #(.DW(DW), .AW(AW)) u_sq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(sq_clear), .i_start(sq_start),
        .i_diff(ad), .o_busy(sq_busy), .o_sum(sq_sum));

    pcop_isqrt #(.AW(AW)) u_rt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(rt_start), .i_rad(sq_sum),
        .o_busy(rt_busy), .o_root(root));

    // Classification on the three distances.
    always_comb begin
        sum_lr = (RW+17)'(r_dl) + (RW+17)'(r_dr);
        lhs1 = (RW+17)'(r_dt);
        rhs1 = sum_lr + (RW+17)'(r_tol);
        lhs2 = (RW+17)'(r_dt) + (RW+17)'(r_tol);
    end

    // Output register: classify in the first output cycle, then hold until the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == pcop_pkg::t_st_out && !r_ovalid) begin
            r_ovalid <= 1'b1;
        end else if (r_ovalid && out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
        if (r_state == pcop_pkg::t_st_out && !r_ovalid) begin
            if (lhs1 < rhs1 && lhs2 > sum_lr) begin
                r_kind <= pcop_pkg::KIND_LINE; r_p1 <= r_gy; r_p2 <= r_ly;
            end else if (r_dr > r_dl) begin
                r_kind <= pcop_pkg::KIND_CORNER_LOW; r_p1 <= r_lx; r_p2 <= r_ly;
            end else if (r_dl > r_dr) begin
                r_kind <= pcop_pkg::KIND_CORNER_HIGH; r_p1 <= r_gy; r_p2 <= r_lx;
            end else begin
                r_kind <= pcop_pkg::KIND_NONE; r_p1 <= '0; r_p2 <= '0;
            end
        end
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.outline_kind = r_kind;
    assign out_ch.first_x = r_p1[3*CW-1:2*CW];
    assign out_ch.first_y = r_p1[2*CW-1:CW];
    assign out_ch.first_z = r_p1[CW-1:0];
    assign out_ch.second_x = r_p2[3*CW-1:2*CW];
    assign out_ch.second_y = r_p2[2*CW-1:CW];
    assign out_ch.second_z = r_p2[CW-1:0];

    `ASSERT_IMPLY(a_no_in_busy, i_clk, i_rst_n, r_state != pcop_pkg::t_st_idle, !in_ch.ready)
    `ASSERT_IMPLY(a_out_state, i_clk, i_rst_n, out_ch.valid, r_state == pcop_pkg::t_st_out)
    `ASSERT_NEXT(a_last_go, i_clk, i_rst_n, in_go && in_ch.last_point, r_state == pcop_pkg::t_st_load)
endmodule

FILE: src/pcop_sq_acc.sv
`include "assert_macros.svh"
// Bit-serial squarer: adds d*d into an accumulator, one multiplier bit per cycle.
module pcop_sq_acc #(
    parameter int DW = 17,
    parameter int AW = 36
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_start,
    input  logic [DW-1:0] i_diff,
    output logic          o_busy,
    output logic [AW-1:0] o_sum
);
    localparam int CW = $clog2(DW + 1);
    logic [DW-1:0] r_mplier;
    logic [AW-1:0] r_sum, r_shift;
    logic [CW-1:0] r_cnt;
    logic          r_busy;

    // Shift-and-add: the multiplicand shifts up as multiplier bits shift out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_sum <= '0;
        end else if (r_busy && r_mplier[0]) begin
            r_sum <= r_sum + r_shift;
        end
        if (i_start) begin
            r_mplier <= i_diff;
            r_shift <= AW'(i_diff);
        end else if (r_busy) begin
            r_mplier <= r_mplier >> 1;
            r_shift <= r_shift << 1;
        end
    end

    assign o_busy = r_busy;
    assign o_sum = r_sum;

    `ASSERT_NEXT(a_cnt_done, i_clk, i_rst_n, r_busy && r_cnt == CW'(1), !r_busy)
    `ASSERT_IMPLY(a_cnt_live, i_clk, i_rst_n, r_busy, r_cnt != '0)
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy)
endmodule

FILE: src/pcop_isqrt.sv
`include "assert_macros.svh"
// Restoring integer square root, one result bit per cycle.
module pcop_isqrt #(
    parameter int AW = 36
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [AW-1:0]   i_rad,
    output logic            o_busy,
    output logic [AW/2-1:0] o_root
);
    localparam int RW = AW / 2;
    localparam int CW = $clog2(RW + 1);
    logic [AW-1:0] r_rad;
    logic [RW+1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [RW+1:0] trial, shifted;

    // Bring down two radicand bits, try root*4+1.
    always_comb begin
        shifted = {r_rem[RW-1:0], r_rad[AW-1 -: 2]};
        trial = shifted - {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= CW'(RW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad <= i_rad;
            r_rem <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= r_rad << 2;
            if (!trial[RW+1]) begin
                r_rem <= trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

    `ASSERT_NEXT(a_done, i_clk, i_rst_n, r_busy && r_cnt == CW'(1), !r_busy)
    `ASSERT_IMPLY(a_live, i_clk, i_rst_n, r_busy, r_cnt != '0)
    `ASSERT_NEXT(a_start, i_clk, i_rst_n, i_start, r_busy)
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } point_t;

    typedef struct packed {
        logic [1:0] kind;
        point_t     first;
        point_t     second;
    } outline_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    pcop_in_if  #(.COORD_WIDTH(16)) in_ch ();
    pcop_out_if #(.COORD_WIDTH(16)) out_ch ();

    point_cluster_outline_picker #(.COORD_WIDTH(16)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state: tolerance and the three tracked extremes.
    logic [15:0] tolerance = pcop_pkg::TOL_RESET;
    bit          cluster_open = 1'b0;
    point_t      top_pt, bottom_pt, left_pt;
    outline_t    outlines_due[$];
    int          errors = 0;
    int          send_gap_pct = 0;
    int          recv_gap_pct = 0;
    int          hold_off_cycles = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.x_coord = '0;
        in_ch.y_coord = '0;
        in_ch.z_coord = '0;
        in_ch.last_point = 1'b0;
        out_ch.ready = 1'b0;
    end

    // Floor square root of the exact squared distance between two points.
    function automatic longint unsigned point_distance(point_t a, point_t b);
        longint signed dx, dy, dz;
        longint unsigned sum, root, trial;
        dx = longint'(a.x) - longint'(b.x);
        dy = longint'(a.y) - longint'(b.y);
        dz = longint'(a.z) - longint'(b.z);
        sum = dx * dx + dy * dy + dz * dz;
        root = 0;
        for (int b_i = 20; b_i >= 0; b_i--) begin
            trial = root | (64'd1 << b_i);
            if (trial * trial <= sum) root = trial;
        end
        return root;
    endfunction

    // Track extremes for one point and queue the outline on the last point.
    function automatic void track_point(point_t p, bit last);
        longint unsigned dl, dr, dt, s;
        outline_t o;
        if (!cluster_open) begin
            top_pt = p;
            bottom_pt = p;
            left_pt = p;
            cluster_open = 1'b1;
        end else begin
            if (p.y > top_pt.y) top_pt = p;
            if (p.y < bottom_pt.y) bottom_pt = p;
            if (p.x < left_pt.x) left_pt = p;
        end
        if (!last) return;
        cluster_open = 1'b0;
        dl = point_distance(top_pt, left_pt);
        dr = point_distance(bottom_pt, left_pt);
        dt = point_distance(top_pt, bottom_pt);
        s = dl + dr;
        if (dt < s + tolerance && dt + tolerance > s) begin
            o = '{pcop_pkg::KIND_LINE, top_pt, bottom_pt};
        end else if (dr > dl) begin
            o = '{pcop_pkg::KIND_CORNER_LOW, left_pt, bottom_pt};
        end else if (dl > dr) begin
            o = '{pcop_pkg::KIND_CORNER_HIGH, top_pt, left_pt};
        end else begin
            o = '{pcop_pkg::KIND_NONE, '0, '0};
        end
        outlines_due = {outlines_due, o};
    endfunction

    // Offer one point and wait for its transfer; valid stays up for a following point.
    task automatic send_point(point_t p, bit last);
        while ($urandom_range(99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.x_coord <= p.x;
        in_ch.y_coord <= p.y;
        in_ch.z_coord <= p.z;
        in_ch.last_point <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        track_point(p, last);
    endtask

    // Receiver ready, with random stalls and an optional long hold-off.
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Compare each result transfer with the oldest expected outline.
    always @(posedge i_clk) begin
        outline_t got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.outline_kind,
                    '{out_ch.first_x, out_ch.first_y, out_ch.first_z},
                    '{out_ch.second_x, out_ch.second_y, out_ch.second_z}};
            if (outlines_due.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = outlines_due.pop_front();
                if (got.kind != want.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                    errors++;
                end
                if (got.first != want.first) begin
                    $display("%0t: first expected %h actual %h", $time, want.first, got.first);
                    errors++;
                end
                if (got.second != want.second) begin
                    $display("%0t: second expected %h actual %h", $time,
                        want.second, got.second);
                    errors++;
                end
            end
        end
    end

    // Stop offering points and wait until every expected result has come.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (outlines_due.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_tolerance(logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        tolerance = v;
    endtask

    function automatic point_t random_point(int span);
        point_t p;
        if (span >= 32768) begin
            p.x = 16'($urandom);
            p.y = 16'($urandom);
            p.z = 16'($urandom);
        end else begin
            p.x = 16'(int'($urandom_range(2 * span)) - span);
            p.y = 16'(int'($urandom_range(2 * span)) - span);
            p.z = 16'(int'($urandom_range(2 * span)) - span);
        end
        return p;
    endfunction

    // Extremes of the coordinates, single points, ties, collinear and cornered clusters and tolerances.
    task automatic test_directed();
        point_t p;
        send_point('{16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b1);
        send_point('{-16'sh8000, -16'sh8000, -16'sh8000}, 1'b0);
        send_point('{16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b1);
        send_point('{16'sh7fff, -16'sh8000, 16'sh7fff}, 1'b0);
        send_point('{-16'sh8000, 16'sh7fff, -16'sh8000}, 1'b1);
        // Line along y.
        for (int i = 0; i < 4; i++) send_point('{16'sd0, 16'(i * 256), 16'sd5}, i == 3);
        // Corner toward least y and toward greatest y.
        send_point('{16'sd0, 16'sd0, 16'sd0}, 1'b0);
        send_point('{16'sd100, -16'sd2000, 16'sd0}, 1'b0);
        send_point('{16'sd50, 16'sd100, 16'sd0}, 1'b1);
        send_point('{16'sd0, 16'sd0, 16'sd0}, 1'b0);
        send_point('{16'sd100, 16'sd2000, 16'sd0}, 1'b0);
        send_point('{16'sd50, -16'sd100, 16'sd0}, 1'b1);
        // Ties keep the earlier point.
        send_point('{16'sd3, 16'sd3, 16'sd1}, 1'b0);
        send_point('{16'sd3, 16'sd3, 16'sd2}, 1'b0);
        send_point('{16'sd3, 16'sd3, 16'sd9}, 1'b1);
        // Symmetric corner: equal sides, no line.
        send_point('{16'sd0, 16'sd0, 16'sd0}, 1'b0);
        send_point('{16'sd1000, 16'sd1000, 16'sd0}, 1'b0);
        send_point('{16'sd1000, -16'sd1000, 16'sd0}, 1'b1);
        set_tolerance(16'd0);
        send_point('{16'sd7, -16'sd7, 16'sd7}, 1'b1);
        set_tolerance(16'hffff);
        p = random_point(32768);
        send_point(p, 1'b0);
        send_point(random_point(32768), 1'b1);
        set_tolerance(pcop_pkg::TOL_RESET);
    endtask

    // Random clusters, mostly small, with random coordinate spans.
    task automatic test_random(int n_points);
        int sent = 0;
        int len, span;
        while (sent < n_points) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(6, 1);
            span = ($urandom_range(3) == 0) ? 32768 : $urandom_range(2000, 1);
            for (int i = 0; i < len; i++) begin
                send_point(random_point(span), i == len - 1);
                sent++;
            end
        end
    endtask

    // Receiver holds off so the block fills up and stalls its input.
    task automatic test_back_pressure();
        drain();
        hold_off_cycles = 2000;
        for (int i = 0; i < 6; i++) send_point(random_point(500), 1'b1);
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_gap_pct = 7;
        recv_gap_pct = 57;
        test_random(330);
        set_tolerance(16'd200);
        send_gap_pct = 57;
        recv_gap_pct = 7;
        test_random(330);
        set_tolerance(16'd1);
        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_random(330);
        test_back_pressure();
        set_tolerance(16'd65535);
        test_random(40);
        drain();
        if (errors == 0 && outlines_due.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule

FILE: files.f
+incdir+src
src/pcop_pkg.sv
src/pcop_in_if.sv
src/pcop_out_if.sv
src/pcop_sq_acc.sv
src/pcop_isqrt.sv
src/point_cluster_outline_picker.sv
tb/tb_top.sv
